### src/gls_pkg.sv
// Shared constants, types and helpers for the grid line sensor model.
package gls_pkg;

  localparam int NUM_ELEMENTS_DEF = 8;
  localparam int MASK_W           = 8;
  localparam int POS_W            = 24;
  localparam int HEAD_W           = 16;
  localparam int OFS_W            = 12;
  localparam int PITCH_W          = 12;
  localparam int HW_W             = 11;
  localparam int LAT_W            = 13;
  localparam int TRIG_W           = 16;
  localparam int PROD_W           = 29;
  localparam int FINE_W           = 36;
  localparam int MM_W             = 21;
  localparam int REM_W            = PITCH_W + 1;
  localparam int CX_W             = 34;
  localparam int CZ_W             = 21;
  localparam int CORDIC_STEPS     = 16;
  localparam int CORDIC_PER_STAGE = 4;
  localparam int CORDIC_STAGES    = CORDIC_STEPS / CORDIC_PER_STAGE;
  localparam int LAT_CORDIC       = CORDIC_STAGES + 2;
  localparam int DIV_PER_STAGE    = 3;
  localparam int DIV_STAGES       = MM_W / DIV_PER_STAGE;
  localparam int LAT_LANE         = DIV_STAGES + 4;
  localparam int ELEM_FIRST       = -35;
  localparam int ELEM_SPACING     = 10;
  localparam int CORDIC_START     = 652032874;
  localparam int CFG_IDX_W        = 3;

  localparam logic signed [OFS_W-1:0] FWD_RST   = 12'sd200;
  localparam logic signed [OFS_W-1:0] LAT_RST   = -12'sd40;
  localparam logic [PITCH_W-1:0]      PITCH_RST = 12'd500;
  localparam logic [HW_W-1:0]         HW_RST    = 11'd15;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FWD_OFS = 3'd0,
    CFG_LAT_OFS = 3'd1,
    CFG_PITCH   = 3'd2,
    CFG_HALF_W  = 3'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [PITCH_W-1:0]      pitch;
    logic [HW_W-1:0]         half_w;
    logic signed [REM_W-1:0] far_lim;
  } lane_cfg_t;

  function automatic logic signed [CZ_W-1:0] atan_f(input int i);
    case (i)
      0:       return CZ_W'(131072);
      1:       return CZ_W'(77376);
      2:       return CZ_W'(40884);
      3:       return CZ_W'(20753);
      4:       return CZ_W'(10417);
      5:       return CZ_W'(5213);
      6:       return CZ_W'(2607);
      7:       return CZ_W'(1304);
      8:       return CZ_W'(652);
      9:       return CZ_W'(326);
      10:      return CZ_W'(163);
      11:      return CZ_W'(81);
      12:      return CZ_W'(41);
      13:      return CZ_W'(20);
      14:      return CZ_W'(10);
      15:      return CZ_W'(5);
      default: return '0;
    endcase
  endfunction

  function automatic logic [REM_W-1:0] rem_step(input logic [REM_W-1:0] rem,
                                                input logic b,
                                                input logic [PITCH_W-1:0] pitch);
    logic [REM_W-1:0] t;
    t = {rem[REM_W-2:0], b};
    if (t >= {1'b0, pitch}) begin
      t = t - {1'b0, pitch};
    end
    return t;
  endfunction

endpackage

### src/gls_cordic.sv
// Pipelined CORDIC giving Q1.15 cosine and sine of a binary-angle heading.
module gls_cordic
  import gls_pkg::*;
(
  input  logic                     clk_i,
  input  logic [HEAD_W-1:0]        heading_i,
  output logic signed [TRIG_W-1:0] cos_o,
  output logic signed [TRIG_W-1:0] sin_o
);

  logic [1:0]              quad_d;
  logic [HEAD_W-1:0]       hsum;
  logic [HEAD_W-1:0]       resid;
  logic signed [CZ_W-1:0]  z_init;

  logic signed [CX_W-1:0]  x_q [CORDIC_STAGES+1];
  logic signed [CX_W-1:0]  y_q [CORDIC_STAGES+1];
  logic signed [CZ_W-1:0]  z_q [CORDIC_STAGES+1];
  logic [1:0]              quad_q [CORDIC_STAGES+1];

  logic signed [TRIG_W-1:0] c_r, s_r, cos_d, sin_d, cos_q, sin_q;

  always_comb begin
    hsum   = heading_i + HEAD_W'(8192);
    quad_d = hsum[HEAD_W-1:HEAD_W-2];
    resid  = heading_i - {quad_d, {(HEAD_W-2){1'b0}}};
    z_init = {{(CZ_W-HEAD_W-4){resid[HEAD_W-1]}}, resid, 4'b0000};
  end

  always_ff @(posedge clk_i) begin
    x_q[0]    <= CX_W'(CORDIC_START);
    y_q[0]    <= '0;
    z_q[0]    <= z_init;
    quad_q[0] <= quad_d;
  end

  for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_stage
    logic signed [CX_W-1:0] x_n, y_n;
    logic signed [CZ_W-1:0] z_n;

    always_comb begin
      logic signed [CX_W-1:0] tx, ty, dx, dy;
      logic signed [CZ_W-1:0] tz;
      tx = x_q[s];
      ty = y_q[s];
      tz = z_q[s];
      for (int j = 0; j < CORDIC_PER_STAGE; j++) begin
        dx = ty >>> (s * CORDIC_PER_STAGE + j);
        dy = tx >>> (s * CORDIC_PER_STAGE + j);
        if (!tz[CZ_W-1]) begin
          tx = tx - dx;
          ty = ty + dy;
          tz = tz - atan_f(s * CORDIC_PER_STAGE + j);
        end else begin
          tx = tx + dx;
          ty = ty - dy;
          tz = tz + atan_f(s * CORDIC_PER_STAGE + j);
        end
      end
      x_n = tx;
      y_n = ty;
      z_n = tz;
    end

    always_ff @(posedge clk_i) begin
      x_q[s+1]    <= x_n;
      y_q[s+1]    <= y_n;
      z_q[s+1]    <= z_n;
      quad_q[s+1] <= quad_q[s];
    end
  end

  // Q.30 to Q1.15, half away from zero, clipped to +-32767
  function automatic logic signed [TRIG_W-1:0] to_q15(input logic signed [CX_W-1:0] v);
    logic [CX_W-1:0] m;
    logic [CX_W-1:0] r;
    m = v[CX_W-1] ? CX_W'(-v) : CX_W'(v);
    r = (m + CX_W'(16384)) >> 15;
    if (r > CX_W'(32767)) begin
      r = CX_W'(32767);
    end
    return v[CX_W-1] ? -TRIG_W'(r) : TRIG_W'(r);
  endfunction

  always_comb begin
    c_r = to_q15(x_q[CORDIC_STAGES]);
    s_r = to_q15(y_q[CORDIC_STAGES]);
    case (quad_q[CORDIC_STAGES])
      2'd1: begin
        cos_d = -s_r;
        sin_d = c_r;
      end
      2'd2: begin
        cos_d = -c_r;
        sin_d = -s_r;
      end
      2'd3: begin
        cos_d = s_r;
        sin_d = -c_r;
      end
      default: begin
        cos_d = c_r;
        sin_d = s_r;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    cos_q <= cos_d;
    sin_q <= sin_d;
  end

  assign cos_o = cos_q;
  assign sin_o = sin_q;

endmodule

### src/gls_lane.sv
// One sensor element: position, floor to mm, pipelined floor modulo and line test.
module gls_lane
  import gls_pkg::*;
(
  input  logic                     clk_i,
  input  lane_cfg_t                cfg_i,
  input  logic signed [OFS_W-1:0]  fwd_i,
  input  logic signed [LAT_W-1:0]  lat_i,
  input  logic signed [TRIG_W-1:0] cos_i,
  input  logic signed [TRIG_W-1:0] sin_i,
  input  logic signed [POS_W-1:0]  pos_x_i,
  input  logic signed [POS_W-1:0]  pos_y_i,
  output logic                     hit_o
);

  logic signed [PROD_W-1:0] fc_q, fs_q, lc_q, ls_q;
  logic signed [POS_W-1:0]  px_q, py_q;
  logic signed [FINE_W-1:0] fine_x, fine_y;
  logic signed [MM_W-1:0]   mm_q [2];
  logic [REM_W-1:0]         rem_q [2][DIV_STAGES+1];
  logic [MM_W-1:0]          dvd_q [2][DIV_STAGES+1];
  logic                     neg_q [2][DIV_STAGES+1];
  logic                     near [2];
  logic                     hit_q;

  always_ff @(posedge clk_i) begin
    fc_q <= PROD_W'(fwd_i) * PROD_W'(cos_i);
    fs_q <= PROD_W'(fwd_i) * PROD_W'(sin_i);
    lc_q <= PROD_W'(lat_i) * PROD_W'(cos_i);
    ls_q <= PROD_W'(lat_i) * PROD_W'(sin_i);
    px_q <= pos_x_i;
    py_q <= pos_y_i;
  end

  always_comb begin
    fine_x = {px_q[POS_W-1], px_q, 11'b0} + FINE_W'(fc_q) - FINE_W'(ls_q);
    fine_y = {py_q[POS_W-1], py_q, 11'b0} + FINE_W'(fs_q) + FINE_W'(lc_q);
  end

  always_ff @(posedge clk_i) begin
    mm_q[0] <= fine_x[FINE_W-1:15];
    mm_q[1] <= fine_y[FINE_W-1:15];
  end

  for (genvar c = 0; c < 2; c++) begin : g_axis
    always_ff @(posedge clk_i) begin
      rem_q[c][0] <= '0;
      neg_q[c][0] <= mm_q[c][MM_W-1];
      dvd_q[c][0] <= mm_q[c][MM_W-1] ? MM_W'(-mm_q[c]) : MM_W'(mm_q[c]);
    end

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
      logic [REM_W-1:0] rem_n;
      logic [MM_W-1:0]  dvd_n;

      always_comb begin
        rem_n = rem_q[c][s];
        dvd_n = dvd_q[c][s];
        for (int j = 0; j < DIV_PER_STAGE; j++) begin
          rem_n = rem_step(rem_n, dvd_n[MM_W-1], cfg_i.pitch);
          dvd_n = dvd_n << 1;
        end
      end

      always_ff @(posedge clk_i) begin
        rem_q[c][s+1] <= rem_n;
        dvd_q[c][s+1] <= dvd_n;
        neg_q[c][s+1] <= neg_q[c][s];
      end
    end

    always_comb begin
      logic [REM_W-1:0] r;
      r = rem_q[c][DIV_STAGES];
      if (neg_q[c][DIV_STAGES] && (r != '0)) begin
        r = {1'b0, cfg_i.pitch} - r;
      end
      near[c] = !((r > REM_W'(cfg_i.half_w)) && ($signed(r) < cfg_i.far_lim));
    end
  end

  always_ff @(posedge clk_i) begin
    hit_q <= near[0] | near[1];
  end

  assign hit_o = hit_q;

endmodule

### src/grid_line_sensor_model.sv
// Top level of the grid line sensor model: config registers, pose pipeline, lanes.
//
//  channel   | ports                                  | transfer
//  ----------+----------------------------------------+----------------------------
//  pose in   | start, busy, pos_x_i, pos_y_i, heading_i | start high and busy low
//  config    | cfg_we_i, cfg_idx_i, cfg_wdata_i       | cfg_we_i high
//  mask out  | done_o, hit_mask_o                     | done_o high, one cycle
//
// One transaction per cycle; each result appears once its pose has passed through:
// one input register, six CORDIC stages (angle set-up, four stages of four iterations,
// rounding) and eleven lane stages, of which seven take the remainder of the 21-bit
// value at three bits each. busy stays low. Reset clears the valid pipeline and loads
// the register defaults. The receiver cannot stall, so nothing is held back.
module grid_line_sensor_model
  import gls_pkg::*;
#(
  parameter int NUM_ELEMENTS = NUM_ELEMENTS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [POS_W-1:0] pos_x_i,
  input  logic signed [POS_W-1:0] pos_y_i,
  input  logic [HEAD_W-1:0]       heading_i,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [OFS_W-1:0]        cfg_wdata_i,
  output logic                    done_o,
  output logic [MASK_W-1:0]       hit_mask_o
);

  localparam int PIPE_DEPTH = 1 + LAT_CORDIC + LAT_LANE;

  logic signed [OFS_W-1:0] fwd_q, lat_q;
  logic [PITCH_W-1:0]      pitch_q;
  logic [HW_W-1:0]         hw_q;
  logic [PIPE_DEPTH-1:0]   vld_q;
  logic                    take;

  logic signed [POS_W-1:0] px_q [LAT_CORDIC+1];
  logic signed [POS_W-1:0] py_q [LAT_CORDIC+1];
  logic [HEAD_W-1:0]       head_q;

  logic signed [TRIG_W-1:0] cos_w, sin_w;
  lane_cfg_t                lane_cfg;
  logic [PITCH_W-1:0]       pitch_eff;
  logic [NUM_ELEMENTS-1:0]  hit;

  assign busy = 1'b0;
  assign take = start & ~busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q   <= FWD_RST;
      lat_q   <= LAT_RST;
      pitch_q <= PITCH_RST;
      hw_q    <= HW_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_FWD_OFS: fwd_q   <= cfg_wdata_i;
        CFG_LAT_OFS: lat_q   <= cfg_wdata_i;
        CFG_PITCH:   pitch_q <= cfg_wdata_i;
        CFG_HALF_W:  hw_q    <= cfg_wdata_i[HW_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[PIPE_DEPTH-2:0], take};
    end
  end

  always_ff @(posedge clk_i) begin
    px_q[0] <= pos_x_i;
    py_q[0] <= pos_y_i;
    head_q  <= heading_i;
    for (int i = 0; i < LAT_CORDIC; i++) begin
      px_q[i+1] <= px_q[i];
      py_q[i+1] <= py_q[i];
    end
  end

  gls_cordic u_cordic (
    .clk_i     (clk_i),
    .heading_i (head_q),
    .cos_o     (cos_w),
    .sin_o     (sin_w)
  );

  // a pitch of zero behaves as one
  assign pitch_eff        = (pitch_q == '0) ? PITCH_W'(1) : pitch_q;
  assign lane_cfg.pitch   = pitch_eff;
  assign lane_cfg.half_w  = hw_q;
  assign lane_cfg.far_lim = $signed({1'b0, pitch_eff}) - $signed(REM_W'(hw_q));

  for (genvar k = 0; k < NUM_ELEMENTS; k++) begin : g_lane
    logic signed [LAT_W-1:0] lat_k;
    assign lat_k = LAT_W'(lat_q) + LAT_W'(ELEM_FIRST + k * ELEM_SPACING);

    gls_lane u_lane (
      .clk_i   (clk_i),
      .cfg_i   (lane_cfg),
      .fwd_i   (fwd_q),
      .lat_i   (lat_k),
      .cos_i   (cos_w),
      .sin_i   (sin_w),
      .pos_x_i (px_q[LAT_CORDIC]),
      .pos_y_i (py_q[LAT_CORDIC]),
      .hit_o   (hit[k])
    );
  end

  for (genvar b = 0; b < MASK_W; b++) begin : g_mask
    if (b < NUM_ELEMENTS) begin : g_on
      assign hit_mask_o[b] = hit[b];
    end else begin : g_off
      assign hit_mask_o[b] = 1'b0;
    end
  end

  assign done_o = vld_q[PIPE_DEPTH-1];

  a_done_traces_take : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(take, PIPE_DEPTH))
    else $error("result without a matching transaction");

  a_take_gives_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |-> ##PIPE_DEPTH done_o)
    else $error("transaction lost in pipeline");

  a_never_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && $past(start)) |-> !busy)
    else $error("pose rejected while streaming");

endmodule
